### hdl/npc_pkg.sv
// Shared types and constants for the nearest palette color block.
package npc_pkg;

   localparam int PALETTE_ENTRIES_DEF = 256;
   localparam int COMP_W  = 8;
   localparam int ENTRY_W = 3 * COMP_W;
   localparam int DIST_W  = 18;
   localparam int SQ_W    = 2 * COMP_W;

   // Starting bound of the search, above every reachable distance.
   localparam logic [DIST_W-1:0] DIST_BOUND = DIST_W'(256 * 256 * 3);

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

endpackage

### hdl/npc_search.sv
// Squared distance pipeline and running minimum over the palette sweep.
module npc_search #(
   parameter int IDX_W = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  npc_pkg::ctl_type                      in_ctl,
   input  logic [IDX_W-1:0]                      in_idx,
   input  logic [npc_pkg::ENTRY_W-1:0]           pixel,
   input  logic [npc_pkg::ENTRY_W-1:0]           entry,
   output logic                                  done,
   output logic [IDX_W-1:0]                      best_idx,
   output logic [npc_pkg::DIST_W-1:0]            best_dist
);

   function automatic logic [npc_pkg::SQ_W-1:0] sq_diff(
      input logic [npc_pkg::COMP_W-1:0] a,
      input logic [npc_pkg::COMP_W-1:0] b
   );
      logic [npc_pkg::COMP_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return npc_pkg::SQ_W'(d) * npc_pkg::SQ_W'(d);
   endfunction

   localparam int CW = npc_pkg::COMP_W;

   npc_pkg::ctl_type             a_ctl_ff, a_ctl_in;
   logic [IDX_W-1:0]             a_idx_ff, a_idx_in;
   logic [npc_pkg::SQ_W-1:0]     sq_r_ff, sq_g_ff, sq_b_ff;
   logic [npc_pkg::SQ_W-1:0]     sq_r_in, sq_g_in, sq_b_in;
   logic [npc_pkg::DIST_W-1:0]   sum;
   logic                         better;
   logic [npc_pkg::DIST_W-1:0]   best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]             best_idx_ff, best_idx_in;
   logic                         done_ff, done_in;

   // stage A: per-channel squares
   always_comb begin
      a_ctl_in = in_ctl;
      a_idx_in = in_idx;
      sq_r_in  = sq_diff(pixel[3*CW-1:2*CW], entry[3*CW-1:2*CW]);
      sq_g_in  = sq_diff(pixel[2*CW-1:CW],   entry[2*CW-1:CW]);
      sq_b_in  = sq_diff(pixel[CW-1:0],      entry[CW-1:0]);
   end

   // stage B: sum and strict-less compare keeps the lowest index on ties
   always_comb begin
      sum = npc_pkg::DIST_W'(sq_r_ff) + npc_pkg::DIST_W'(sq_g_ff)
          + npc_pkg::DIST_W'(sq_b_ff);
      better = a_ctl_ff.valid && (sum < best_dist_ff);
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      if (start) begin
         best_dist_in = npc_pkg::DIST_BOUND;
         best_idx_in  = '0;
      end else if (better) begin
         best_dist_in = sum;
         best_idx_in  = a_idx_ff;
      end
      done_in = a_ctl_ff.valid && a_ctl_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         a_ctl_ff <= a_ctl_in;
         done_ff  <= done_in;
      end
      a_idx_ff     <= a_idx_in;
      sq_r_ff      <= sq_r_in;
      sq_g_ff      <= sq_g_in;
      sq_b_ff      <= sq_b_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
   end

   assign done      = done_ff;
   assign best_idx  = best_idx_ff;
   assign best_dist = best_dist_ff;

   a_no_start_mid_sweep: assert property (@(posedge clock) disable iff (reset)
      start |-> !a_ctl_ff.valid)
      else $error("search restarted while entries in flight");

   a_done_below_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (best_dist_ff < npc_pkg::DIST_BOUND))
      else $error("search finished without a candidate");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("double completion pulse");

endmodule

### hdl/nearest_palette_color.sv
// Nearest palette color: palette memory, sweep control and result register.
// Write transfer: taken one per cycle back to back while no query is in progress.
// Query transfer: the sweep reads the palette one entry per cycle; the next
// item is taken once the result is in the output register, so a new query is not
// accepted while the previous one is still in flight.
// Reset clears control state only; palette contents are undefined until written.
module nearest_palette_color #(
   parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // color_index[7:0], distance[25:8], exact_match[26]
);

   localparam int AW = $clog2(PALETTE_ENTRIES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SWEEP = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type                       state_ff, state_in;
   logic [AW-1:0]                   addr_ff, addr_in;
   logic [npc_pkg::ENTRY_W-1:0]     mem [PALETTE_ENTRIES];
   logic [npc_pkg::ENTRY_W-1:0]     rdata_ff;
   npc_pkg::ctl_type                rd_ctl_ff, rd_ctl_in;
   logic [AW-1:0]                   rd_idx_ff;
   logic [npc_pkg::ENTRY_W-1:0]     px_ff, px_in;
   logic                            res_pend_ff, res_pend_in;
   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0]                     rsp_tdata_ff, rsp_tdata_in;

   logic                            req_fire;
   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic                            q_start;
   logic                            rd_en;
   logic                            load_out;
   logic                            srch_done;
   logic [AW-1:0]                   best_idx;
   logic [npc_pkg::DIST_W-1:0]      best_dist;
   logic                            exact;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign wr_addr    = AW'(req_tdata[7:0]);
   assign wr_en      = req_fire && (req_tuser == npc_pkg::CMD_WRITE)
                    && (32'(req_tdata[7:0]) < 32'(PALETTE_ENTRIES));
   assign q_start    = req_fire && (req_tuser == npc_pkg::CMD_QUERY);
   assign rd_en      = (state_ff == ST_SWEEP);
   assign load_out   = (state_ff == ST_DRAIN) && res_pend_ff
                    && (!rsp_tvalid_ff || rsp_tready);
   assign exact      = (best_dist == '0);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_tdata[31:8];
      end
      if (rd_en) begin
         rdata_ff <= mem[addr_ff];
      end
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      px_in         = px_ff;
      res_pend_in   = res_pend_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rd_ctl_in.valid = rd_en;
      rd_ctl_in.last  = rd_en && (addr_ff == LAST_ADDR);

      case (state_ff)
         ST_IDLE: begin
            if (q_start) begin
               state_in = ST_SWEEP;
               addr_in  = '0;
               px_in    = req_tdata[31:8];
            end
         end
         ST_SWEEP: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (srch_done) begin
         res_pend_in = 1'b1;
      end else if (load_out) begin
         res_pend_in = 1'b0;
      end

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (load_out) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {5'b0, exact, best_dist, 8'(best_idx)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_ctl_ff     <= '0;
         res_pend_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_ctl_ff     <= rd_ctl_in;
         res_pend_ff   <= res_pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      addr_ff      <= addr_in;
      rd_idx_ff    <= addr_ff;
      px_ff        <= px_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   npc_search #(
      .IDX_W (AW)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .start     (q_start),
      .in_ctl    (rd_ctl_ff),
      .in_idx    (rd_idx_ff),
      .pixel     (px_ff),
      .entry     (rdata_ff),
      .done      (srch_done),
      .best_idx  (best_idx),
      .best_dist (best_dist)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      srch_done |-> (state_ff == ST_DRAIN) && !res_pend_ff)
      else $error("search completion outside drain");

   a_rsp_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_DRAIN))
      else $error("result raised outside drain");

   a_exact_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (rsp_tdata_ff[26] == (rsp_tdata_ff[25:8] == '0)))
      else $error("exact flag disagrees with distance");

endmodule

### tb/npc_match_check.sv
`timescale 1ns / 1ps
// Channel monitor that predicts and checks nearest palette matches.
module npc_match_check #(
   parameter int ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
   input  logic        req_tuser,   // cmd
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // color_index[7:0], distance[25:8], exact_match[26]
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic                       exact;
      logic [npc_pkg::DIST_W-1:0] distance;
      logic [7:0]                 idx;
   } match_type;

   logic [npc_pkg::ENTRY_W-1:0] palette [ENTRIES];
   match_type                   matches_due [$];
   int                          mismatches = 0;

   function automatic int sq_gap(input logic [7:0] a, input logic [7:0] b);
      int d;
      d = int'(a) - int'(b);
      return d * d;
   endfunction

   function automatic match_type nearest_entry(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
      match_type m;
      int        best_dist;
      int        best_idx;
      int        d;
      best_dist = int'(npc_pkg::DIST_BOUND);
      best_idx  = 0;
      for (int i = 0; i < ENTRIES; i++) begin
         d = sq_gap(r, palette[i][23:16]) + sq_gap(g, palette[i][15:8])
           + sq_gap(b, palette[i][7:0]);
         // strict compare keeps the lowest index on ties
         if (d < best_dist) begin
            best_dist = d;
            best_idx  = i;
         end
      end
      m.idx      = best_idx[7:0];
      m.distance = best_dist[npc_pkg::DIST_W-1:0];
      m.exact    = (best_dist == 0);
      return m;
   endfunction

   always @(posedge clock) begin
      match_type  got;
      match_type  want;
      logic [7:0] idx;
      if (reset) begin
         matches_due.delete();
         pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = match_type'(rsp_tdata[26:0]);
            if (matches_due.size() == 0) begin
               fail_count++;
               if (mismatches < 10)
                  $display("unexpected result transfer: idx %0d dist %0d exact %0b",
                           got.idx, got.distance, got.exact);
               mismatches++;
            end else begin
               want = matches_due.pop_front();
               if (got.idx !== want.idx || got.distance !== want.distance
                   || got.exact !== want.exact) begin
                  fail_count++;
                  if (mismatches < 10)
                     $display({"result mismatch: expected idx %0d dist %0d exact %0b,",
                               " got idx %0d dist %0d exact %0b"},
                              want.idx, want.distance, want.exact,
                              got.idx, got.distance, got.exact);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            idx = req_tdata[7:0];
            if (npc_pkg::cmd_type'(req_tuser) == npc_pkg::CMD_WRITE) begin
               if (int'(idx) < ENTRIES)
                  palette[idx] = {req_tdata[15:8], req_tdata[23:16], req_tdata[31:24]};
            end else begin
               matches_due.push_back(nearest_entry(req_tdata[15:8], req_tdata[23:16],
                                                   req_tdata[31:24]));
            end
         end
         pending <= matches_due.size();
      end
   end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the nearest palette color block: clock, reset, stimulus and verdict.
module tb;

   localparam int ENTRIES       = npc_pkg::PALETTE_ENTRIES_DEF;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = ENTRIES + 40;
   localparam int IDLE_PCT      = 8;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [31:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [31:0] rsp_tdata;

   int          fail_count;
   int          pending;
   int          cycles = 0;
   bit          calm   = 1'b0;
   logic [23:0] shade [ENTRIES];

   nearest_palette_color #(.PALETTE_ENTRIES(ENTRIES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   npc_match_check #(.ENTRIES(ENTRIES)) match_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   function automatic logic [7:0] level(input bit coarse);
      return coarse ? 8'($urandom_range(3) * 85) : 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] jitter(input logic [7:0] v);
      int t;
      t = int'(v) + int'($urandom_range(8)) - 4;
      if (t < 0) t = 0;
      if (t > 255) t = 255;
      return 8'(t);
   endfunction

   task automatic send_item(input npc_pkg::cmd_type cmd, input logic [7:0] idx,
                            input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {b, g, r, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (cmd == npc_pkg::CMD_WRITE && int'(idx) < ENTRIES) shade[idx] = {r, g, b};
   endtask

   task automatic drain_results;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic load_palette(input bit coarse);
      for (int i = 0; i < ENTRIES; i++)
         send_item(npc_pkg::CMD_WRITE, 8'(i), level(coarse), level(coarse), level(coarse));
   endtask

   task automatic run_mix(input int count, input bit coarse);
      logic [23:0] c;
      int          pick;
      for (int n = 0; n < count; n++) begin
         c    = shade[$urandom_range(ENTRIES - 1)];
         pick = $urandom_range(99);
         if (pick < 20)
            send_item(npc_pkg::CMD_QUERY, 8'($urandom), c[23:16], c[15:8], c[7:0]);
         else if (pick < 35)
            send_item(npc_pkg::CMD_QUERY, 8'($urandom), jitter(c[23:16]), jitter(c[15:8]),
                      jitter(c[7:0]));
         else if (pick < 40)
            send_item(npc_pkg::CMD_QUERY, 8'($urandom), level(coarse), level(coarse),
                      level(coarse));
         else if (pick < 45)
            send_item(npc_pkg::CMD_QUERY, 8'($urandom), level(0), level(0), level(0));
         else if (pick < 55)
            // duplicate color of another entry
            send_item(npc_pkg::CMD_WRITE, 8'($urandom), c[23:16], c[15:8], c[7:0]);
         else
            send_item(npc_pkg::CMD_WRITE, 8'($urandom), level(coarse), level(coarse),
                      level(coarse));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // all black palette; white pixel gives the largest distance, entry 0 from the bound
      for (int i = 0; i < ENTRIES; i++)
         send_item(npc_pkg::CMD_WRITE, 8'(i), 8'h00, 8'h00, 8'h00);
      send_item(npc_pkg::CMD_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_item(npc_pkg::CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(npc_pkg::CMD_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_item(npc_pkg::CMD_QUERY, 8'h5A, 8'hFF, 8'hFF, 8'hFF);
      send_item(npc_pkg::CMD_QUERY, 8'hA5, 8'h80, 8'h80, 8'h80);
      send_item(npc_pkg::CMD_WRITE, 8'h80, 8'hFF, 8'hFF, 8'hFF);
      send_item(npc_pkg::CMD_QUERY, 8'h00, 8'hFF, 8'hFE, 8'hFF);
      // equal distances to entries 10, 20 and every black entry
      send_item(npc_pkg::CMD_WRITE, 8'h00, 8'hFF, 8'hFF, 8'h00);
      send_item(npc_pkg::CMD_WRITE, 8'd10, 8'd10, 8'h00, 8'h00);
      send_item(npc_pkg::CMD_WRITE, 8'd20, 8'h00, 8'd10, 8'h00);
      send_item(npc_pkg::CMD_QUERY, 8'h33, 8'd5, 8'd5, 8'h00);
      drain_results();

      // coarse grid palette: many duplicates and ties
      load_palette(1'b1);
      run_mix(150, 1'b1);

      // fine levels written over the coarse palette
      run_mix(80, 1'b0);
      calm = 1'b1;
      run_mix(80, 1'b0);
      calm = 1'b0;
      drain_results();
      run_mix(70, 1'b0);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
